/* sv/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Shared field widths, command codes and the request, response and
// arithmetic-unit struct types.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int CMD_W   = 3;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 32;
   localparam int MASK_W  = 16;

   // Milliseconds per second and the split point of the tick conversion.
   localparam int          MS_PER_S = 1000;
   localparam logic [31:0] MS_SPLIT = 32'd1000000;

   // Reciprocal of 1000 scaled by 2^38; exact quotient for any 32-bit dividend.
   localparam logic [31:0] MS_RECIP       = 32'h1062_4DD3;
   localparam int          MS_RECIP_SHIFT = 38;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] timer_index;
      logic [31:0]      duration_ms;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic [CNT_W-1:0]  count_value;
   } rsp_type;

   // Operands of the shared add and compare unit.
   typedef struct packed {
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] b;
      logic             inc;
   } alu_req_type;

   // Results of the shared add and compare unit.
   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic             ge;
   } alu_rsp_type;

endpackage

/* sv/ptb_ram.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ptb_alu.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank add and compare unit
// Shared unit: adds an optional increment to one operand and compares the
// sum against the other, giving the sum and a greater-or-equal flag.
// ----------------------------------------------------------------------------
module ptb_alu (
   input  ptb_pkg::alu_req_type op,
   output ptb_pkg::alu_rsp_type res
);
   import ptb_pkg::*;

   logic [CNT_W-1:0] sum;
   logic [CNT_W:0]   wide_diff;

   // Increment wraps at the word width, then a subtract gives the compare.
   assign sum       = op.a + CNT_W'(op.inc);
   assign wide_diff = {1'b0, sum} - {1'b0, op.b};

   assign res.sum  = sum;
   assign res.ge   = ~wide_diff[CNT_W];

endmodule

/* sv/periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank
// A bank of periodic timers with start, restart, enable, disable, read and
// tick commands, built around one shared add and compare unit.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the req_ channel and exactly one result
// beat leaves on the rsp_ channel. A tick sweeps the bank one timer per cycle
// through the add and compare unit and returns the fired mask; a read returns
// the addressed count; every other command returns zeros.
// From acceptance to the result register: a tick runs the sweep (one read
// per timer), drains the update stage and hands over; a start runs a
// multiply by the tick rate and a reciprocal multiply for the divide by
// 1000, in either order, then the write and the hand-over; a read runs the
// read, the read wait and the hand-over; restart, enable and disable run the
// write and the hand-over; an unknown code or an out-of-range index hands over.
// Only one command is in flight: req_stall is high from acceptance until the
// result is handed to the output register, and the next command can be
// taken in the cycle after. The output register holds its beat while
// rsp_stall is high, and a new command may be accepted meanwhile.
// Reset clears all enables, marks every stored period and count as unwritten
// (reading as all ones and zero) and empties the result register; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_timer_bank #(
   parameter int NUM_TIMERS   = 16,
   parameter int TICK_RATE_HZ = 1000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptb_pkg::rsp_type rsp_data
);
   import ptb_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SW = $clog2(NUM_TIMERS + 1);
   localparam int DW = 2 * CNT_W;
   localparam logic [CNT_W-1:0] RATE = CNT_W'(TICK_RATE_HZ);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_TICK = 8'b0000_0010,
      S_RD   = 8'b0000_0100,
      S_RDW  = 8'b0000_1000,
      S_MUL  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_WR   = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic              big_ff, big_in;
   logic [SW-1:0]     sweep_ff, sweep_in;
   logic              s1_vld_ff, s1_vld_in;
   logic [IW-1:0]     s1_idx_ff, s1_idx_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]  cnt_out_ff, cnt_out_in;
   logic [DW-1:0]     div_ff, div_in;
   logic [NUM_TIMERS-1:0] enable_ff, enable_in;
   logic [NUM_TIMERS-1:0] per_vld_ff, per_vld_in;
   logic [NUM_TIMERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic              pv_q_ff, cv_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              in_idx_ok;
   logic [IW-1:0]     req_addr;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [CNT_W-1:0]  per_rd, cnt_rd;
   logic [CNT_W-1:0]  per_eff, cnt_eff;
   logic              per_we, cnt_we;
   logic [IW-1:0]     wr_addr;
   logic [CNT_W-1:0]  per_wd, cnt_wd;
   logic [CNT_W-1:0]  mul_a, mul_b;
   logic [DW-1:0]     product;
   logic [CNT_W-1:0]  period_sat;
   logic              issue;
   logic              load_rsp;
   alu_req_type       alu_op;
   alu_rsp_type       alu_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign in_idx_ok = (int'(req_data.timer_index) < NUM_TIMERS);
   assign req_addr  = IW'(req_ff.timer_index);

   // Unwritten entries read as their reset values.
   assign per_eff = pv_q_ff ? per_rd : '1;
   assign cnt_eff = cv_q_ff ? cnt_rd : '0;

   // One multiplier serves the scaling by the tick rate and the reciprocal
   // divide by 1000; the multiplier always takes its working value from the low word.
   assign mul_a   = div_ff[CNT_W-1:0];
   assign mul_b   = (state_ff == S_DIV) ? MS_RECIP : RATE;
   assign product = DW'(mul_a) * DW'(mul_b);

   // Saturate the converted period at all ones.
   assign period_sat = (|div_ff[DW-1:CNT_W]) ? '1 : div_ff[CNT_W-1:0];

   // Operand selection for the shared unit.
   always_comb begin
      alu_op.a   = cnt_eff;
      alu_op.b   = per_eff;
      alu_op.inc = 1'b1;
   end

   ptb_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   ptb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TIMERS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (wr_addr),
      .wr_data (per_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rd)
   );

   ptb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TIMERS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      big_in     = big_ff;
      sweep_in   = sweep_ff;
      s1_vld_in  = 1'b0;
      s1_idx_in  = s1_idx_ff;
      mask_in    = mask_ff;
      cnt_out_in = cnt_out_ff;
      div_in     = div_ff;
      enable_in  = enable_ff;
      per_vld_in = per_vld_ff;
      cnt_vld_in = cnt_vld_ff;
      rd_en      = 1'b0;
      rd_addr    = req_addr;
      per_we     = 1'b0;
      cnt_we     = 1'b0;
      wr_addr    = req_addr;
      per_wd     = period_sat;
      cnt_wd     = '0;
      issue      = 1'b0;
      load_rsp   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               mask_in    = '0;
               cnt_out_in = '0;
               big_in     = (req_data.duration_ms > MS_SPLIT);
               priority if (req_data.cmd == CMD_TICK) begin
                  sweep_in = '0;
                  state_in = S_TICK;
               end else if (!in_idx_ok) begin
                  state_in = S_DONE;
               end else if (req_data.cmd == CMD_START) begin
                  div_in   = DW'(req_data.duration_ms);
                  state_in = (req_data.duration_ms > MS_SPLIT) ? S_DIV : S_MUL;
               end else if (req_data.cmd == CMD_READ) begin
                  state_in = S_RD;
               end else if (req_data.cmd == CMD_RESTART || req_data.cmd == CMD_ENABLE ||
                            req_data.cmd == CMD_DISABLE) begin
                  state_in = S_WR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_TICK: begin
            // Issue one read per cycle while the second stage updates.
            issue     = (int'(sweep_ff) < NUM_TIMERS);
            rd_en     = issue;
            rd_addr   = IW'(sweep_ff);
            s1_vld_in = issue;
            s1_idx_in = IW'(sweep_ff);
            if (issue) begin
               sweep_in = sweep_ff + SW'(1);
            end
            if (s1_vld_ff && enable_ff[s1_idx_ff]) begin
               cnt_we                = 1'b1;
               wr_addr               = s1_idx_ff;
               cnt_wd                = alu_res.ge ? '0 : alu_res.sum;
               cnt_vld_in[s1_idx_ff] = 1'b1;
               for (int j = 0; j < MASK_W; j++) begin
                  if (alu_res.ge && int'(s1_idx_ff) == j) begin
                     mask_in[j] = 1'b1;
                  end
               end
            end
            if (!issue && !s1_vld_ff) begin
               state_in = S_DONE;
            end
         end

         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_RDW;
         end

         S_RDW: begin
            cnt_out_in = cnt_eff;
            state_in   = S_DONE;
         end

         S_MUL: begin
            div_in   = product;
            state_in = big_ff ? S_WR : S_DIV;
         end

         S_DIV: begin
            // Quotient by 1000 from the high bits of the reciprocal product.
            div_in   = DW'(product[DW-1:MS_RECIP_SHIFT]);
            state_in = big_ff ? S_MUL : S_WR;
         end

         S_WR: begin
            unique case (req_ff.cmd)
               CMD_START: begin
                  per_we               = 1'b1;
                  cnt_we               = 1'b1;
                  per_vld_in[req_addr] = 1'b1;
                  cnt_vld_in[req_addr] = 1'b1;
                  enable_in[req_addr]  = 1'b1;
               end
               CMD_RESTART: begin
                  cnt_we               = 1'b1;
                  cnt_vld_in[req_addr] = 1'b1;
               end
               CMD_ENABLE: begin
                  enable_in[req_addr] = 1'b1;
               end
               CMD_DISABLE: begin
                  enable_in[req_addr] = 1'b0;
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register between the sequencer and the receiver.
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = load_rsp ? rsp_type'{fired_mask: mask_ff, count_value: cnt_out_ff}
                                  : rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         s1_vld_ff    <= 1'b0;
         enable_ff    <= '0;
         per_vld_ff   <= '0;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         enable_ff    <= enable_in;
         per_vld_ff   <= per_vld_in;
         cnt_vld_ff   <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      big_ff     <= big_in;
      sweep_ff   <= sweep_in;
      s1_idx_ff  <= s1_idx_in;
      mask_ff    <= mask_in;
      cnt_out_ff <= cnt_out_in;
      div_ff     <= div_in;
      pv_q_ff    <= per_vld_ff[rd_addr];
      cv_q_ff    <= cnt_vld_ff[rd_addr];
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result beat never carries both a fired mask and a count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.fired_mask == '0) || (rsp_ff.count_value == '0))
      else $error("result beat carries both a fired mask and a count");

   // The divide step hands over to the multiply or to the write.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_MUL) || (state_ff == S_WR))
      else $error("divide step left for an unexpected state");

   // A stalled result beat stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result beat changed");

   // Loading a result returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == S_IDLE))
      else $error("result loaded without returning to idle");

endmodule

/* tb/periodic_timer_bank_tb.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives command beats into the timer bank and checks every result beat
// against a cycle-free model of the bank. A directed opening covers every
// command, the field extremes, the conversion split point, zero and unit
// periods and the unused codes. A long random run follows, with random idle
// bursts on both channels, one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module periodic_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptb_pkg::*;

   localparam int N_TIMERS     = 16;
   localparam int RATE_HZ      = 1000;
   localparam int RANDOM_ITEMS = 500;
   localparam int LONG_HOLD    = 150;
   localparam int TAIL_CYCLES  = 64;
   localparam int IDLE_LIMIT   = 4000;
   localparam int PRINT_LIMIT  = 100;

   // Codes the block does not define; they must leave the bank untouched.
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   // Model of the bank and the queue of results still owed by the block.
   class timer_scoreboard;
      logic [CNT_W-1:0] period_q [N_TIMERS];
      logic [CNT_W-1:0] count_q [N_TIMERS];
      bit               enabled [N_TIMERS];
      rsp_type          due_results [$];
      int               errors;

      function new();
         for (int i = 0; i < N_TIMERS; i++) begin
            period_q[i] = '1;
            count_q[i]  = '0;
            enabled[i]  = 1'b0;
         end
         errors = 0;
      endfunction

      // Milliseconds to ticks, with the coarse path above the split point.
      function logic [CNT_W-1:0] duration_to_ticks(logic [31:0] ms);
         logic [63:0] ticks;
         if (ms > MS_SPLIT) begin
            ticks = (64'(ms) / 64'(MS_PER_S)) * 64'(RATE_HZ);
         end else begin
            ticks = (64'(ms) * 64'(RATE_HZ)) / 64'(MS_PER_S);
         end
         if (ticks > 64'hFFFF_FFFF) begin
            ticks = 64'hFFFF_FFFF;
         end
         return ticks[CNT_W-1:0];
      endfunction

      // Applies one command to the model and returns the result it causes.
      function rsp_type step_bank(req_type beat);
         rsp_type          res;
         logic [CNT_W-1:0] next_count;
         int               idx;
         res = '0;
         idx = int'(beat.timer_index);
         if (beat.cmd == CMD_TICK) begin
            for (int i = 0; i < N_TIMERS; i++) begin
               if (enabled[i]) begin
                  next_count = count_q[i] + 1'b1;
                  if (next_count >= period_q[i]) begin
                     count_q[i] = '0;
                     if (i < MASK_W) begin
                        res.fired_mask[i] = 1'b1;
                     end
                  end else begin
                     count_q[i] = next_count;
                  end
               end
            end
         end else if (idx < N_TIMERS) begin
            case (beat.cmd)
               CMD_START: begin
                  period_q[idx] = duration_to_ticks(beat.duration_ms);
                  count_q[idx]  = '0;
                  enabled[idx]  = 1'b1;
               end
               CMD_RESTART: count_q[idx] = '0;
               CMD_ENABLE:  enabled[idx] = 1'b1;
               CMD_DISABLE: enabled[idx] = 1'b0;
               CMD_READ:    res.count_value = count_q[idx];
               default: ;
            endcase
         end
         return res;
      endfunction

      function void note_command(req_type beat);
         due_results.push_back(step_bank(beat));
      endfunction

      // Prints are capped so that a broken block cannot flood the log.
      task report_mismatch(input string what);
         errors++;
         if (errors <= PRINT_LIMIT) begin
            $display("mismatch %0d at %0t: %s", errors, $realtime, what);
         end
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %h", got));
         end else begin
            want = due_results.pop_front();
            if (got.fired_mask !== want.fired_mask) begin
               report_mismatch($sformatf("fired_mask %h, expected %h",
                                         got.fired_mask, want.fired_mask));
            end
            if (got.count_value !== want.count_value) begin
               report_mismatch($sformatf("count_value %h, expected %h",
                                         got.count_value, want.count_value));
            end
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   timer_scoreboard board = new();
   bit              idling;
   bit              hold_wanted;
   int              idle_cycles;

   periodic_timer_bank #(
      .NUM_TIMERS  (N_TIMERS),
      .TICK_RATE_HZ(RATE_HZ)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_type make_beat(logic [CMD_W-1:0] cmd, int idx,
                                         logic [31:0] ms);
      req_type beat;
      beat.cmd         = cmd;
      beat.timer_index = IDX_W'(idx);
      beat.duration_ms = ms;
      return beat;
   endfunction

   // Random command mix: ticks dominate and most periods are short, so
   // timers keep expiring; a few starts use wide or split-point durations.
   function automatic req_type random_beat();
      req_type beat;
      int      pick;
      int      span;
      pick = $urandom_range(0, 99);
      span = $urandom_range(0, 99);
      beat.timer_index = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      beat.duration_ms = $urandom();
      if (pick < 42) begin
         beat.cmd = CMD_TICK;
      end else if (pick < 58) begin
         beat.cmd = CMD_START;
         if (span < 70) begin
            beat.duration_ms = $urandom_range(0, 24);
         end else if (span < 85) begin
            beat.duration_ms = MS_SPLIT - 32'd2 + 32'($urandom_range(0, 4));
         end
      end else if (pick < 67) begin
         beat.cmd = CMD_RESTART;
      end else if (pick < 76) begin
         beat.cmd = CMD_ENABLE;
      end else if (pick < 84) begin
         beat.cmd = CMD_DISABLE;
      end else if (pick < 97) begin
         beat.cmd = CMD_READ;
      end else if (pick < 99) begin
         beat.cmd = CMD_SPARE_A;
      end else begin
         beat.cmd = CMD_SPARE_B;
      end
      return beat;
   endfunction

   // Offers one beat and returns at the edge that accepts it. Valid stays
   // high afterwards unless the next call opens a gap or the channel is
   // released.
   task automatic send_beat(input req_type beat);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_command(beat);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_beat(random_beat());
      end
   endtask

   task automatic send_directed();
      // All disabled: a tick with extreme ignored fields fires nothing.
      send_beat(make_beat(CMD_TICK, 15, 32'hFFFF_FFFF));
      send_beat(make_beat(CMD_READ, 0, 32'hFFFF_FFFF));
      send_beat(make_beat(CMD_READ, 15, 32'h0));
      // Zero and unit periods, the split point and the widest duration.
      send_beat(make_beat(CMD_START, 0, 32'd0));
      send_beat(make_beat(CMD_START, 15, 32'd1));
      send_beat(make_beat(CMD_START, 7, 32'd2));
      send_beat(make_beat(CMD_START, 3, MS_SPLIT));
      send_beat(make_beat(CMD_START, 4, MS_SPLIT + 32'd1));
      send_beat(make_beat(CMD_START, 5, 32'hFFFF_FFFF));
      send_beat(make_beat(CMD_START, 6, 32'd999));
      send_beat(make_beat(CMD_TICK, 0, 32'd0));
      send_beat(make_beat(CMD_TICK, 9, 32'h5A5A_A5A5));
      send_beat(make_beat(CMD_READ, 7, 32'd0));
      send_beat(make_beat(CMD_READ, 3, 32'd0));
      send_beat(make_beat(CMD_RESTART, 3, 32'hFFFF_FFFF));
      send_beat(make_beat(CMD_READ, 3, 32'd0));
      // Disable keeps the count; enable resumes from it.
      send_beat(make_beat(CMD_DISABLE, 0, 32'd0));
      send_beat(make_beat(CMD_TICK, 0, 32'd0));
      send_beat(make_beat(CMD_ENABLE, 0, 32'd0));
      send_beat(make_beat(CMD_TICK, 0, 32'd0));
      // Unused codes change nothing and return zeros.
      send_beat(make_beat(CMD_SPARE_A, 10, 32'hAAAA_AAAA));
      send_beat(make_beat(CMD_SPARE_B, 5, 32'h5555_5555));
      send_beat(make_beat(CMD_DISABLE, 15, 32'd0));
      send_beat(make_beat(CMD_READ, 5, 32'd0));
      send_beat(make_beat(CMD_TICK, 15, 32'd0));
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : rsp_side
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         board.check_result(rsp_data);
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      idling      = 1'b0;
      hold_wanted = 1'b0;
      idle_cycles = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_directed();

      // Random traffic with idle bursts on both sides.
      idling = 1'b1;
      send_random(RANDOM_ITEMS * 3 / 10);

      // Long receiver hold-off while commands keep coming.
      hold_wanted = 1'b1;
      send_random(RANDOM_ITEMS / 5);

      // Sender pauses until the bank has answered everything.
      drain_results();
      send_random(RANDOM_ITEMS / 5);

      // Last stretch runs at full rate on both sides.
      idling = 1'b0;
      send_random(RANDOM_ITEMS * 3 / 10);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.due_results.size() != 0) begin
         board.report_mismatch($sformatf("%0d results never arrived",
                                         board.due_results.size()));
      end
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
